// ----- src/fola_pkg.sv -----
// Package with the types, codes and sizes of the first-come lock arbiter.
`default_nettype none

package fola_pkg;

  localparam int REQUESTERS = 16;
  localparam int IDX_W      = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int CNT_W      = $clog2(REQUESTERS + 1);
  localparam int CMD_W      = 2;
  localparam int REQ_W      = 4;
  localparam int STATUS_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOCK   = 2'd0,
    CMD_TRY    = 2'd1,
    CMD_UNLOCK = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED         = 3'd0,
    ST_QUEUED_BLOCKED  = 3'd1,
    ST_QUEUED_TRYFAIL  = 3'd2,
    ST_TRYFAIL_WAITING = 3'd3,
    ST_ERROR           = 3'd4,
    ST_UNLOCKED        = 3'd5,
    ST_IGNORED         = 3'd6
  } status_e;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [REQUESTERS-1:0] mask_t;

endpackage

`default_nettype wire

// ----- src/fola_req_if.sv -----
// Request channel: command and requester id with a valid/ready handshake.
`default_nettype none

interface fola_req_if
  import fola_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [REQ_W-1:0] requester;

  modport source (output valid, output command, output requester, input ready);
  modport sink   (input valid, input command, input requester, output ready);
endinterface

`default_nettype wire

// ----- src/fola_rsp_if.sv -----
// Response channel: grant, status and handoff fields with a valid/ready handshake.
`default_nettype none

interface fola_rsp_if
  import fola_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                granted;
  logic [STATUS_W-1:0] status;
  logic                handoff_valid;
  logic [REQ_W-1:0]    handoff_id;
  logic                handoff_wakes;

  modport source (output valid, output granted, output status, output handoff_valid,
                  output handoff_id, output handoff_wakes, input ready);
  modport sink   (input valid, input granted, input status, input handoff_valid,
                  input handoff_id, input handoff_wakes, output ready);
endinterface

`default_nettype wire

// ----- src/fifo_ordered_lock_arbiter_top.sv -----
// Top level of the first-come lock arbiter: owner, wait queue and per-id flags.
//
//   channel  direction  payload
//   req_i    in         command, requester
//   rsp_o    out        granted, status, handoff_valid, handoff_id, handoff_wakes
//
// An item is registered on acceptance and resolved once the output register is free,
// when its response is written to the output register.
// One item per cycle is accepted as long as responses are taken.
// A stalled response holds the input register, and then the input channel stalls.
// Reset clears the owner, the flags and the queue pointers; no clearing pass is needed.
`default_nettype none

module fifo_ordered_lock_arbiter_top
  import fola_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fola_req_if.sink    req_i,
  fola_rsp_if.source  rsp_o
);

  logic             in_valid_q;
  logic [CMD_W-1:0] cmd_q;
  logic [REQ_W-1:0] req_q;

  logic             out_valid_q;
  logic             granted_q, granted_d;
  status_e          status_q, status_d;
  logic             hv_q, hv_d;
  logic [REQ_W-1:0] hid_q, hid_d;
  logic             hw_q, hw_d;

  logic  owner_valid_q, owner_valid_d;
  idx_t  owner_id_q, owner_id_d;
  mask_t waiting_q, waiting_d;
  mask_t blocked_q, blocked_d;
  mask_t pending_q, pending_d;
  idx_t  head_q, head_d;
  cnt_t  count_q, count_d;

  idx_t  queue_mem [REQUESTERS];
  idx_t  head_val_q;
  logic  q_we;
  idx_t  q_waddr;

  logic  advance;
  logic  id_ok;
  idx_t  r;
  idx_t  nxt;
  idx_t  tail;
  cnt_t  tail_sum;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  assign id_ok    = (int'(req_q) < REQUESTERS);
  assign r        = IDX_W'(req_q);
  assign nxt      = head_val_q;
  assign tail_sum = CNT_W'(head_q) + count_q;
  assign tail     = (int'(tail_sum) >= REQUESTERS) ? IDX_W'(tail_sum - CNT_W'(REQUESTERS))
                                                   : IDX_W'(tail_sum);

  always_comb begin
    owner_valid_d = owner_valid_q;
    owner_id_d    = owner_id_q;
    waiting_d     = waiting_q;
    blocked_d     = blocked_q;
    pending_d     = pending_q;
    head_d        = head_q;
    count_d       = count_q;
    q_we          = 1'b0;
    q_waddr       = tail;
    granted_d     = 1'b0;
    status_d      = ST_IGNORED;
    hv_d          = 1'b0;
    hid_d         = '0;
    hw_d          = 1'b0;
    if (advance && id_ok) begin
      unique case (cmd_e'(cmd_q))
        CMD_LOCK, CMD_TRY: begin
          if (!owner_valid_q) begin
            owner_valid_d = 1'b1;
            owner_id_d    = r;
            waiting_d[r]  = 1'b0;
            blocked_d[r]  = 1'b0;
            pending_d[r]  = 1'b0;
            granted_d     = 1'b1;
            status_d      = ST_GRANTED;
          end else if (waiting_q[r]) begin
            if (cmd_e'(cmd_q) == CMD_LOCK) begin
              status_d = ST_ERROR;
            end else if (pending_q[r]) begin
              pending_d[r] = 1'b0;
              waiting_d[r] = 1'b0;
              granted_d    = 1'b1;
              status_d     = ST_GRANTED;
            end else begin
              status_d = ST_TRYFAIL_WAITING;
            end
          end else if (owner_id_q == r) begin
            granted_d = 1'b1;
            status_d  = ST_GRANTED;
          end else begin
            if (int'(count_q) < REQUESTERS) begin
              q_we    = 1'b1;
              count_d = count_q + cnt_t'(1);
            end
            waiting_d[r] = 1'b1;
            if (cmd_e'(cmd_q) == CMD_TRY) begin
              status_d = ST_QUEUED_TRYFAIL;
            end else begin
              blocked_d[r] = 1'b1;
              status_d     = ST_QUEUED_BLOCKED;
            end
          end
        end
        CMD_UNLOCK: begin
          if (owner_valid_q && owner_id_q == r) begin
            waiting_d[r] = 1'b0;
            pending_d[r] = 1'b0;
            blocked_d[r] = 1'b0;
            status_d     = ST_UNLOCKED;
            if (count_q == '0) begin
              owner_valid_d = 1'b0;
            end else begin
              head_d     = (int'(head_q) == REQUESTERS - 1) ? '0 : head_q + idx_t'(1);
              count_d    = count_q - cnt_t'(1);
              owner_id_d = nxt;
              hv_d       = 1'b1;
              hid_d      = REQ_W'(nxt);
              if (blocked_d[nxt]) begin
                blocked_d[nxt] = 1'b0;
                waiting_d[nxt] = 1'b0;
                pending_d[nxt] = 1'b0;
                hw_d           = 1'b1;
              end else begin
                pending_d[nxt] = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      owner_valid_q <= 1'b0;
      owner_id_q    <= '0;
      waiting_q     <= '0;
      blocked_q     <= '0;
      pending_q     <= '0;
      head_q        <= '0;
      count_q       <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      owner_valid_q <= owner_valid_d;
      owner_id_q    <= owner_id_d;
      waiting_q     <= waiting_d;
      blocked_q     <= blocked_d;
      pending_q     <= pending_d;
      head_q        <= head_d;
      count_q       <= count_d;
    end
  end

  // The entry at the queue head is kept in a register so the handoff reads no memory.
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      cmd_q <= req_i.command;
      req_q <= req_i.requester;
    end
    if (advance) begin
      granted_q <= granted_d;
      status_q  <= status_d;
      hv_q      <= hv_d;
      hid_q     <= hid_d;
      hw_q      <= hw_d;
    end
    if (q_we) begin
      queue_mem[q_waddr] <= r;
    end
    if (q_we && count_q == '0) begin
      head_val_q <= r;
    end else if (hv_d) begin
      head_val_q <= queue_mem[head_d];
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.granted       = granted_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.handoff_valid = hv_q;
  assign rsp_o.handoff_id    = hid_q;
  assign rsp_o.handoff_wakes = hw_q;

endmodule

`default_nettype wire

// ----- verif/tb_fifo_ordered_lock_arbiter_top.sv -----
// Self-checking testbench of the first-come lock arbiter: directed table, then random traffic.
`default_nettype none

module tb_fifo_ordered_lock_arbiter_top;
  import fola_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam int               RANDOM_ITEMS = 1550;
  localparam int               CHUNK_ITEMS  = 50;
  localparam int               MAX_WAIT     = 12;
  localparam int               TAIL_CYCLES  = 8;
  localparam int               WANT_DEPTH   = 16;

  typedef struct packed {
    logic                granted;
    status_e             status;
    logic                handoff_valid;
    logic [REQ_W-1:0]    handoff_id;
    logic                handoff_wakes;
  } outcome_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [REQ_W-1:0] id;
    logic             typed;
    outcome_t         rsp;
  } stim_row_t;

  localparam outcome_t NO_RSP     = '0;
  localparam outcome_t GRANT_RSP  = '{1'b1, ST_GRANTED, 1'b0, 4'd0, 1'b0};
  localparam outcome_t IGNORE_RSP = '{1'b0, ST_IGNORED, 1'b0, 4'd0, 1'b0};
  localparam outcome_t ERROR_RSP  = '{1'b0, ST_ERROR, 1'b0, 4'd0, 1'b0};

  localparam int DIRECTED_ROWS = 24;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_UNLOCK, 4'd0,  1'b1, IGNORE_RSP},
    '{CMD_UNUSED, 4'd15, 1'b1, IGNORE_RSP},
    '{CMD_LOCK,   4'd0,  1'b1, GRANT_RSP},
    '{CMD_LOCK,   4'd0,  1'b1, GRANT_RSP},
    '{CMD_TRY,    4'd15, 1'b0, NO_RSP},
    '{CMD_LOCK,   4'd5,  1'b0, NO_RSP},
    '{CMD_TRY,    4'd15, 1'b0, NO_RSP},
    '{CMD_LOCK,   4'd15, 1'b1, ERROR_RSP},
    '{CMD_LOCK,   4'd5,  1'b1, ERROR_RSP},
    '{CMD_UNLOCK, 4'd3,  1'b1, IGNORE_RSP},
    '{CMD_UNLOCK, 4'd0,  1'b0, NO_RSP},
    '{CMD_UNLOCK, 4'd15, 1'b0, NO_RSP},
    '{CMD_TRY,    4'd15, 1'b0, NO_RSP},
    '{CMD_TRY,    4'd5,  1'b1, GRANT_RSP},
    '{CMD_UNLOCK, 4'd5,  1'b0, NO_RSP},
    '{CMD_TRY,    4'd15, 1'b0, NO_RSP},
    '{CMD_TRY,    4'd15, 1'b1, GRANT_RSP},
    '{CMD_UNUSED, 4'd0,  1'b1, IGNORE_RSP},
    '{CMD_LOCK,   4'd10, 1'b0, NO_RSP},
    '{CMD_UNLOCK, 4'd15, 1'b0, NO_RSP},
    '{CMD_UNLOCK, 4'd10, 1'b0, NO_RSP},
    '{CMD_UNLOCK, 4'd10, 1'b1, IGNORE_RSP},
    '{CMD_TRY,    4'd7,  1'b1, GRANT_RSP},
    '{CMD_UNLOCK, 4'd7,  1'b0, NO_RSP}
  };

  logic clk_i;
  logic rst_ni;

  fola_req_if req_if ();
  fola_rsp_if rsp_if ();

  fifo_ordered_lock_arbiter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic             own_valid;
  logic [REQ_W-1:0] own_id;
  mask_t            wait_mask;
  mask_t            block_mask;
  mask_t            grant_mask;
  logic [REQ_W-1:0] wait_fifo [REQUESTERS];
  idx_t             fifo_head;
  cnt_t             fifo_count;

  outcome_t want_fifo [WANT_DEPTH];
  int       want_wr;
  int       want_rd;
  int       mismatch_count;
  bit       steady;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic outcome_t arbitrate(input logic [CMD_W-1:0] cmd,
                                         input logic [REQ_W-1:0] id);
    outcome_t         o;
    logic [REQ_W-1:0] nxt;
    o = IGNORE_RSP;
    if (cmd == CMD_LOCK || cmd == CMD_TRY) begin
      if (!own_valid) begin
        own_valid      = 1'b1;
        own_id         = id;
        wait_mask[id]  = 1'b0;
        block_mask[id] = 1'b0;
        grant_mask[id] = 1'b0;
        o = GRANT_RSP;
      end else if (wait_mask[id]) begin
        if (cmd == CMD_LOCK) begin
          o.status = ST_ERROR;
        end else if (grant_mask[id]) begin
          grant_mask[id] = 1'b0;
          wait_mask[id]  = 1'b0;
          o = GRANT_RSP;
        end else begin
          o.status = ST_TRYFAIL_WAITING;
        end
      end else if (own_id == id) begin
        o = GRANT_RSP;
      end else begin
        if (int'(fifo_count) < REQUESTERS) begin
          wait_fifo[idx_t'((int'(fifo_head) + int'(fifo_count)) % REQUESTERS)] = id;
          fifo_count = fifo_count + cnt_t'(1);
        end
        wait_mask[id] = 1'b1;
        if (cmd == CMD_TRY) begin
          o.status = ST_QUEUED_TRYFAIL;
        end else begin
          block_mask[id] = 1'b1;
          o.status = ST_QUEUED_BLOCKED;
        end
      end
    end else if (cmd == CMD_UNLOCK && own_valid && own_id == id) begin
      wait_mask[id]  = 1'b0;
      grant_mask[id] = 1'b0;
      block_mask[id] = 1'b0;
      o.status = ST_UNLOCKED;
      if (fifo_count == '0) begin
        own_valid = 1'b0;
      end else begin
        nxt        = wait_fifo[fifo_head];
        fifo_head  = idx_t'((int'(fifo_head) + 1) % REQUESTERS);
        fifo_count = fifo_count - cnt_t'(1);
        own_id     = nxt;
        o.handoff_valid = 1'b1;
        o.handoff_id    = nxt;
        if (block_mask[nxt]) begin
          block_mask[nxt] = 1'b0;
          wait_mask[nxt]  = 1'b0;
          grant_mask[nxt] = 1'b0;
          o.handoff_wakes = 1'b1;
        end else begin
          grant_mask[nxt] = 1'b1;
        end
      end
    end
    return o;
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [REQ_W-1:0] id,
                              input logic typed, input outcome_t typed_rsp);
    int       gap;
    outcome_t predicted;
    gap = draw_wait();
    if (gap > 0) begin
      if (req_if.valid) req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.requester <= id;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = arbitrate(cmd, id);
    want_fifo[want_wr % WANT_DEPTH] = typed ? typed_rsp : predicted;
    want_wr++;
    @(negedge clk_i);
  endtask

  task automatic drain_outcomes();
    if (req_if.valid) req_if.valid <= 1'b0;
    do @(posedge clk_i); while (want_wr != want_rd);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_rsp
    outcome_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (want_wr == want_rd) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = want_fifo[want_rd % WANT_DEPTH];
        want_rd++;
        if (rsp_if.granted !== want.granted)
          report_mismatch($sformatf("granted %b, want %b", rsp_if.granted, want.granted));
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp_if.status, want.status));
        if (rsp_if.handoff_valid !== want.handoff_valid)
          report_mismatch($sformatf("handoff_valid %b, want %b",
                                    rsp_if.handoff_valid, want.handoff_valid));
        if (rsp_if.handoff_id !== want.handoff_id)
          report_mismatch($sformatf("handoff_id %0d, want %0d",
                                    rsp_if.handoff_id, want.handoff_id));
        if (rsp_if.handoff_wakes !== want.handoff_wakes)
          report_mismatch($sformatf("handoff_wakes %b, want %b",
                                    rsp_if.handoff_wakes, want.handoff_wakes));
      end
    end
  end

  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        if (rsp_if.ready) rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      @(negedge clk_i);
    end
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [REQ_W-1:0] id;
    int               served;
    int               unlock_pct;
    int               roll;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.command   = CMD_LOCK;
    req_if.requester = '0;
    own_valid        = 1'b0;
    own_id           = '0;
    wait_mask        = '0;
    block_mask       = '0;
    grant_mask       = '0;
    fifo_head        = '0;
    fifo_count       = '0;
    want_wr          = 0;
    want_rd          = 0;
    mismatch_count   = 0;
    steady           = 1'b0;
    served           = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(DIRECTED[i].cmd, DIRECTED[i].id, DIRECTED[i].typed, DIRECTED[i].rsp);
    end
    drain_outcomes();

    while (served < RANDOM_ITEMS) begin
      steady     = ($urandom_range(0, 3) == 0);
      unlock_pct = $urandom_range(8, 55);
      if ($urandom_range(0, 3) == 0) drain_outcomes();
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        id   = REQ_W'($urandom_range(0, REQUESTERS - 1));
        if (roll < 3) begin
          cmd = CMD_UNUSED;
        end else if (roll < 3 + unlock_pct) begin
          cmd = CMD_UNLOCK;
          if (own_valid && $urandom_range(0, 3) != 0) id = own_id;
        end else begin
          cmd = $urandom_range(0, 1) ? CMD_TRY : CMD_LOCK;
          if (own_valid && $urandom_range(0, 4) == 0) id = own_id;
        end
        send_request(cmd, id, 1'b0, NO_RSP);
        served++;
      end
    end

    req_if.valid <= 1'b0;
    while (want_wr != want_rd) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
